>>> rtl/core/fpp_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the framed
// packet parser. No dependencies; used by fpp_ctrl, fpp_dpath and the top level.
package fpp_pkg;

   // Default payload buffer depth
   localparam int MAX_PAYLOAD_DEF = 64;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int INDEX_W = 6;
   localparam int CRC_W   = 16;
   localparam int CSR_A_W = 8;

   // Register indexes on the csr port
   localparam logic [CSR_A_W-1:0] CSR_SYNC_BYTE  = 8'd0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_LENGTH = 8'd1;

   // Reset values of the registers
   localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
   localparam logic [LEN_W-1:0]  MAXLEN_RESET  = 7'd64;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Commands from controller to datapath
   typedef struct packed {
      logic crc_start;    // start CRC from zero with the current word
      logic crc_feed;     // fold the current word into the running CRC
      logic load_seq;
      logic load_id;
      logic load_len;     // capture length, clear fill index
      logic store_byte;   // write payload word, bump fill index
      logic load_crc_lo;
      logic emit_load;    // load next result into the output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_sync;
      logic len_ok;
      logic len_zero;
      logic fill_done;
      logic crc_match;
      logic out_free;
      logic emit_last;
   } status_type;

   // One byte through CRC-16/XMODEM, MSB first
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/fpp_ctrl.sv
// Frame parsing state machine: decides per word what the datapath does.
// Depends on fpp_pkg (cmd_type, status_type).
module fpp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fpp_pkg::status_type sts,
   output fpp_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_HUNT = 3'd0;
   localparam logic [2:0] ST_SEQ  = 3'd1;
   localparam logic [2:0] ST_ID   = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_DATA = 3'd4;
   localparam logic [2:0] ST_CRC1 = 3'd5;
   localparam logic [2:0] ST_CRC2 = 3'd6;
   localparam logic [2:0] ST_EMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       acc;

   // Input is held off only while a frame is being played out
   assign req_ready = (state_ff != ST_EMIT);
   assign acc       = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (acc && sts.is_sync) begin
               cmd.crc_start = 1'b1;
               state_in      = ST_SEQ;
            end
         end
         ST_SEQ: begin
            if (acc) begin
               cmd.load_seq = 1'b1;
               cmd.crc_feed = 1'b1;
               state_in     = ST_ID;
            end
         end
         ST_ID: begin
            if (acc) begin
               cmd.load_id  = 1'b1;
               cmd.crc_feed = 1'b1;
               state_in     = ST_LEN;
            end
         end
         ST_LEN: begin
            if (acc) begin
               if (!sts.len_ok) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.load_len = 1'b1;
                  cmd.crc_feed = 1'b1;
                  state_in     = sts.len_zero ? ST_CRC1 : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (acc) begin
               cmd.store_byte = 1'b1;
               cmd.crc_feed   = 1'b1;
               if (sts.fill_done) begin
                  state_in = ST_CRC1;
               end
            end
         end
         ST_CRC1: begin
            if (acc) begin
               cmd.load_crc_lo = 1'b1;
               state_in        = ST_CRC2;
            end
         end
         ST_CRC2: begin
            if (acc) begin
               state_in = sts.crc_match ? ST_EMIT : ST_HUNT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/fpp_dpath.sv
// Datapath: config registers, header capture, running CRC, payload buffer
// and the result output register. Depends on fpp_pkg.
module fpp_dpath #(
   parameter int MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [fpp_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [fpp_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic [fpp_pkg::BYTE_W-1:0]    req_rx_byte,
   input  fpp_pkg::cmd_type              cmd,
   output fpp_pkg::status_type           sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_seq_num,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_message_id,
   output logic [fpp_pkg::LEN_W-1:0]     rsp_payload_length,
   output logic [fpp_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_last
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [fpp_pkg::BYTE_W-1:0] MAX_LEN_B = fpp_pkg::BYTE_W'(MAX_PAYLOAD);

   logic [fpp_pkg::BYTE_W-1:0] sync_ff;
   logic [fpp_pkg::LEN_W-1:0]  maxlen_ff;
   logic [fpp_pkg::BYTE_W-1:0] seq_ff, id_ff, crc_lo_ff;
   logic [fpp_pkg::LEN_W-1:0]  len_ff, fill_ff, fill_in;
   logic [fpp_pkg::CRC_W-1:0]  crc_ff, crc_upd;
   logic [AW-1:0]              emit_idx_ff, rd_addr;
   logic [fpp_pkg::BYTE_W-1:0] mem_q_ff;
   logic [fpp_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
   logic                       rsp_valid_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= fpp_pkg::SYNC_RESET;
         maxlen_ff <= fpp_pkg::MAXLEN_RESET;
      end else if (csr_valid) begin
         if (csr_index == fpp_pkg::CSR_SYNC_BYTE) begin
            sync_ff <= csr_wdata;
         end else if (csr_index == fpp_pkg::CSR_MAX_LENGTH) begin
            maxlen_ff <= csr_wdata[fpp_pkg::LEN_W-1:0];
         end
      end
   end

   // CRC update of the current word, from zero at frame start
   assign crc_upd = fpp_pkg::crc_feed(cmd.crc_start ? '0 : crc_ff, req_rx_byte);
   assign fill_in = fill_ff + 7'd1;

   // Header, CRC and fill tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         id_ff     <= '0;
         len_ff    <= '0;
         fill_ff   <= '0;
         crc_ff    <= '0;
         crc_lo_ff <= '0;
      end else begin
         if (cmd.crc_start || cmd.crc_feed) begin
            crc_ff <= crc_upd;
         end
         if (cmd.load_seq) begin
            seq_ff <= req_rx_byte;
         end
         if (cmd.load_id) begin
            id_ff <= req_rx_byte;
         end
         if (cmd.load_len) begin
            len_ff <= req_rx_byte[fpp_pkg::LEN_W-1:0];
         end
         if (cmd.crc_start || cmd.load_len) begin
            fill_ff <= '0;
         end else if (cmd.store_byte) begin
            fill_ff <= fill_in;
         end
         if (cmd.load_crc_lo) begin
            crc_lo_ff <= req_rx_byte;
         end
      end
   end

   // Emit index; it rests at zero between frames
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_idx_ff <= '0;
      end else if (cmd.emit_load) begin
         emit_idx_ff <= sts.emit_last ? '0 : emit_idx_ff + AW'(1);
      end
   end

   // Read ahead one entry so the next result is ready as this one loads
   assign rd_addr = emit_idx_ff + AW'(cmd.emit_load);

   // Payload buffer, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         mem[fill_ff[AW-1:0]] <= req_rx_byte;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Status to the controller
   always_comb begin
      sts.is_sync   = (req_rx_byte == sync_ff);
      sts.len_ok    = !(req_rx_byte > {1'b0, maxlen_ff}) && !(req_rx_byte > MAX_LEN_B);
      sts.len_zero  = (req_rx_byte == '0);
      sts.fill_done = (fill_in >= len_ff);
      sts.crc_match = ({req_rx_byte, crc_lo_ff} == crc_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.emit_last = (len_ff == '0) ||
                      (fpp_pkg::LEN_W'(emit_idx_ff) + 7'd1 == len_ff);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_seq_num        <= seq_ff;
         rsp_message_id     <= id_ff;
         rsp_payload_length <= len_ff;
         rsp_byte_index     <= fpp_pkg::INDEX_W'(emit_idx_ff);
         rsp_data_byte      <= (len_ff == '0) ? '0 : mem_q_ff;
         rsp_has_data       <= (len_ff != '0);
         rsp_last           <= sts.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/framed_packet_parser_crc16.sv
// Framed packet parser with CRC-16/XMODEM check. Input: one word a cycle while
// parsing; each word ahead of the CRC is folded into the CRC in the cycle it
// arrives. On a good CRC the frame is played out from the payload buffer one
// result a cycle while the receiver is ready (len results, or one for an empty
// frame); input is held off for that run. Synchronous active-high reset returns
// to sync hunting with config at defaults; the payload buffer is not cleared.
module framed_packet_parser_crc16 #(
   parameter int MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fpp_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [fpp_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fpp_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_seq_num,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_message_id,
   output logic [fpp_pkg::LEN_W-1:0]     rsp_payload_length,
   output logic [fpp_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [fpp_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_last
);

   fpp_pkg::cmd_type    cmd;
   fpp_pkg::status_type sts;

   // Register writes always taken
   assign csr_ready = 1'b1;

   fpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpp_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_seq_num        (rsp_seq_num),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_last           (rsp_last)
   );

endmodule

>>> test/framed_packet_parser_crc16_tb.sv
// Self-checking bench for framed_packet_parser_crc16: drives link words, predicts
// the accepted frames and checks every result word in order.
// Depends on fpp_pkg and the framed_packet_parser_crc16 RTL only.
module framed_packet_parser_crc16_tb;

   localparam int PAYLOAD_DEPTH = fpp_pkg::MAX_PAYLOAD_DEF;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_BUDGET  = 8;

   // parser phase codes of the predictor
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_SEQ  = 3'd1;
   localparam logic [2:0] PH_ID   = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CRC1 = 3'd5;
   localparam logic [2:0] PH_CRC2 = 3'd6;

   typedef struct packed {
      logic [fpp_pkg::BYTE_W-1:0]  seq_num;
      logic [fpp_pkg::BYTE_W-1:0]  message_id;
      logic [fpp_pkg::LEN_W-1:0]   payload_length;
      logic [fpp_pkg::INDEX_W-1:0] byte_index;
      logic [fpp_pkg::BYTE_W-1:0]  data_byte;
      logic                        has_data;
      logic                        last;
   } frame_word_type;

   // Tracks the parser, queues the words a good frame plays out, checks them
   class frame_book_type;
      logic [fpp_pkg::BYTE_W-1:0]  sync_value;
      logic [fpp_pkg::LEN_W-1:0]   max_len;
      logic [2:0]                  phase;
      logic [fpp_pkg::BYTE_W-1:0]  seq_r;
      logic [fpp_pkg::BYTE_W-1:0]  id_r;
      logic [fpp_pkg::LEN_W-1:0]   len_r;
      logic [fpp_pkg::LEN_W-1:0]   fill;
      logic [fpp_pkg::CRC_W-1:0]   crc;
      logic [fpp_pkg::BYTE_W-1:0]  crc_lo;
      logic [fpp_pkg::BYTE_W-1:0]  store [PAYLOAD_DEPTH];
      frame_word_type              due_payload_words [$];
      int                          mismatches;

      function new();
         sync_value = fpp_pkg::SYNC_RESET;
         max_len    = fpp_pkg::MAXLEN_RESET;
         phase      = PH_HUNT;
         seq_r      = '0;
         id_r       = '0;
         len_r      = '0;
         fill       = '0;
         crc        = '0;
         crc_lo     = '0;
         mismatches = 0;
      endfunction

      // CRC-16/XMODEM, one input bit at a time, MSB first
      static function logic [fpp_pkg::CRC_W-1:0] crc_byte(logic [fpp_pkg::CRC_W-1:0] c,
                                                          logic [fpp_pkg::BYTE_W-1:0] b);
         logic fb;
         for (int i = fpp_pkg::BYTE_W - 1; i >= 0; i--) begin
            fb = c[fpp_pkg::CRC_W-1] ^ b[i];
            c  = {c[fpp_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
               c = c ^ fpp_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_reg(logic [fpp_pkg::CSR_A_W-1:0] idx,
                            logic [fpp_pkg::BYTE_W-1:0] val);
         case (idx)
            fpp_pkg::CSR_SYNC_BYTE: begin
               sync_value = val;
            end
            fpp_pkg::CSR_MAX_LENGTH: begin
               max_len = val[fpp_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // One accepted link word through the parser
      function void take_link_word(logic [fpp_pkg::BYTE_W-1:0] b);
         frame_word_type w;
         unique case (phase)
            PH_HUNT: begin
               if (b == sync_value) begin
                  crc   = crc_byte('0, b);
                  fill  = '0;
                  phase = PH_SEQ;
               end
            end
            PH_SEQ: begin
               seq_r = b;
               crc   = crc_byte(crc, b);
               phase = PH_ID;
            end
            PH_ID: begin
               id_r  = b;
               crc   = crc_byte(crc, b);
               phase = PH_LEN;
            end
            PH_LEN: begin
               // too long for the register or the buffer: drop the frame
               if (b > max_len || int'(b) > PAYLOAD_DEPTH) begin
                  phase = PH_HUNT;
               end else begin
                  len_r = b[fpp_pkg::LEN_W-1:0];
                  crc   = crc_byte(crc, b);
                  fill  = '0;
                  phase = (b == 0) ? PH_CRC1 : PH_DATA;
               end
            end
            PH_DATA: begin
               store[fill[fpp_pkg::INDEX_W-1:0]] = b;
               crc  = crc_byte(crc, b);
               fill = fill + fpp_pkg::LEN_W'(1);
               if (fill >= len_r) begin
                  phase = PH_CRC1;
               end
            end
            PH_CRC1: begin
               crc_lo = b;
               phase  = PH_CRC2;
            end
            PH_CRC2: begin
               phase = PH_HUNT;
               if ({b, crc_lo} == crc) begin
                  w.seq_num    = seq_r;
                  w.message_id = id_r;
                  if (len_r == 0) begin
                     // empty frame: one word without data
                     w.payload_length = '0;
                     w.byte_index     = '0;
                     w.data_byte      = '0;
                     w.has_data       = 1'b0;
                     w.last           = 1'b1;
                     due_payload_words.push_back(w);
                  end else begin
                     for (int k = 0; k < int'(len_r); k++) begin
                        w.payload_length = len_r;
                        w.byte_index     = fpp_pkg::INDEX_W'(k);
                        w.data_byte      = store[k];
                        w.has_data       = 1'b1;
                        w.last           = (k + 1 == int'(len_r));
                        due_payload_words.push_back(w);
                     end
                  end
               end
            end
            default: begin
               phase = PH_HUNT;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [fpp_pkg::BYTE_W-1:0] exp_v,
                                  logic [fpp_pkg::BYTE_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_word(frame_word_type got);
         frame_word_type w;
         if (due_payload_words.size() == 0) begin
            $error("result word with none due: seq_num %0d byte_index %0d",
                   got.seq_num, got.byte_index);
            mismatches++;
            return;
         end
         w = due_payload_words.pop_front();
         compare_field("seq_num", w.seq_num, got.seq_num);
         compare_field("message_id", w.message_id, got.message_id);
         compare_field("payload_length", fpp_pkg::BYTE_W'(w.payload_length),
                       fpp_pkg::BYTE_W'(got.payload_length));
         compare_field("byte_index", fpp_pkg::BYTE_W'(w.byte_index),
                       fpp_pkg::BYTE_W'(got.byte_index));
         compare_field("data_byte", w.data_byte, got.data_byte);
         compare_field("has_data", fpp_pkg::BYTE_W'(w.has_data),
                       fpp_pkg::BYTE_W'(got.has_data));
         compare_field("last", fpp_pkg::BYTE_W'(w.last), fpp_pkg::BYTE_W'(got.last));
      endfunction
   endclass

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [fpp_pkg::CSR_A_W-1:0]  csr_index   = '0;
   logic [fpp_pkg::BYTE_W-1:0]   csr_wdata   = '0;
   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   logic [fpp_pkg::BYTE_W-1:0]   req_rx_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   logic [fpp_pkg::BYTE_W-1:0]   rsp_seq_num;
   logic [fpp_pkg::BYTE_W-1:0]   rsp_message_id;
   logic [fpp_pkg::LEN_W-1:0]    rsp_payload_length;
   logic [fpp_pkg::INDEX_W-1:0]  rsp_byte_index;
   logic [fpp_pkg::BYTE_W-1:0]   rsp_data_byte;
   logic                         rsp_has_data;
   logic                         rsp_last;

   frame_book_type book = new();
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int sent_words     = 0;
   int cycle_count    = 0;

   framed_packet_parser_crc16 uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_seq_num        (rsp_seq_num),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_last           (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // result words, checked in order of arrival
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_word(frame_word_type'{rsp_seq_num, rsp_message_id, rsp_payload_length,
                                          rsp_byte_index, rsp_data_byte, rsp_has_data,
                                          rsp_last});
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[framed_packet_parser_crc16] ERROR");
         $finish;
      end
   end

   // one link word; valid stays up into the next word unless a gap is taken
   task automatic send_word(input logic [fpp_pkg::BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      book.take_link_word(b);
      sent_words++;
   endtask

   // both registers, back to back on the csr channel
   task automatic set_config(input logic [fpp_pkg::BYTE_W-1:0] sync_v,
                             input logic [fpp_pkg::BYTE_W-1:0] len_v);
      csr_valid <= 1'b1;
      csr_index <= fpp_pkg::CSR_SYNC_BYTE;
      csr_wdata <= sync_v;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(fpp_pkg::CSR_SYNC_BYTE, sync_v);
      csr_index <= fpp_pkg::CSR_MAX_LENGTH;
      csr_wdata <= len_v;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(fpp_pkg::CSR_MAX_LENGTH, len_v);
      csr_valid <= 1'b0;
   endtask

   // sender holds off until every due word is out and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (book.due_payload_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [fpp_pkg::BYTE_W-1:0] quiet_word();
      logic [fpp_pkg::BYTE_W-1:0] b;
      b = fpp_pkg::BYTE_W'($urandom);
      if (b == book.sync_value) begin
         b = b + fpp_pkg::BYTE_W'(1);
      end
      return b;
   endfunction

   task automatic flush_to_hunt();
      while (book.phase != PH_HUNT) send_word(quiet_word());
   endtask

   // sync, seq, id, length, payload, CRC low then high; fill < 0 means random
   // payload, cut > 0 keeps only that many leading words
   task automatic send_frame(input logic [fpp_pkg::BYTE_W-1:0] seq,
                             input logic [fpp_pkg::BYTE_W-1:0] id,
                             input logic [fpp_pkg::BYTE_W-1:0] len_code, input int fill,
                             input bit corrupt, input int cut);
      logic [fpp_pkg::BYTE_W-1:0] stream [$];
      logic [fpp_pkg::CRC_W-1:0]  trailer;
      int                         payload_n;
      int                         n;
      stream.push_back(book.sync_value);
      stream.push_back(seq);
      stream.push_back(id);
      stream.push_back(len_code);
      payload_n = (len_code <= book.max_len && int'(len_code) <= PAYLOAD_DEPTH) ?
                  int'(len_code) : 0;
      for (int k = 0; k < payload_n; k++) begin
         stream.push_back(fill < 0 ? fpp_pkg::BYTE_W'($urandom) : fpp_pkg::BYTE_W'(fill));
      end
      trailer = '0;
      foreach (stream[k]) begin
         trailer = frame_book_type::crc_byte(trailer, stream[k]);
      end
      if (corrupt) begin
         trailer = trailer ^ fpp_pkg::CRC_W'(1 << $urandom_range(0, fpp_pkg::CRC_W - 1));
      end
      stream.push_back(trailer[7:0]);
      stream.push_back(trailer[15:8]);
      n = (cut > 0 && cut < stream.size()) ? cut : stream.size();
      for (int k = 0; k < n; k++) begin
         send_word(stream[k]);
      end
   endtask

   // mostly good frames of small length, with bad CRCs, long lengths,
   // cut-off frames and loose noise mixed in
   task automatic random_traffic(input int budget, input bit full_frame);
      int  start;
      int  pick;
      int  len;
      int  top;
      bit  paused;
      start  = sent_words;
      paused = 1'b0;
      if (full_frame) begin
         flush_to_hunt();
         send_frame(fpp_pkg::BYTE_W'($urandom), fpp_pkg::BYTE_W'($urandom),
                    fpp_pkg::BYTE_W'(PAYLOAD_DEPTH), -1, 1'b0, 0);
      end
      while (sent_words - start < budget) begin
         flush_to_hunt();
         pick = $urandom_range(0, 99);
         top  = (book.max_len < 8) ? int'(book.max_len) : 8;
         len  = ($urandom_range(0, 9) == 0) ? int'(book.max_len) : $urandom_range(0, top);
         if (pick < 68) begin
            send_frame(fpp_pkg::BYTE_W'($urandom), fpp_pkg::BYTE_W'($urandom),
                       fpp_pkg::BYTE_W'(len), -1, 1'b0, 0);
         end else if (pick < 78) begin
            send_frame(fpp_pkg::BYTE_W'($urandom), fpp_pkg::BYTE_W'($urandom),
                       fpp_pkg::BYTE_W'(len), -1, 1'b1, 0);
         end else if (pick < 86) begin
            send_frame(fpp_pkg::BYTE_W'($urandom), fpp_pkg::BYTE_W'($urandom),
                       fpp_pkg::BYTE_W'($urandom_range(int'(book.max_len) + 1, 255)),
                       -1, 1'b0, 0);
         end else if (pick < 93) begin
            send_frame(fpp_pkg::BYTE_W'($urandom), fpp_pkg::BYTE_W'($urandom),
                       fpp_pkg::BYTE_W'(len), -1, 1'b0, $urandom_range(1, len + 5));
         end else begin
            repeat ($urandom_range(1, 3)) send_word(fpp_pkg::BYTE_W'($urandom));
         end
         // one mid-phase pause with the sender quiet until all is out
         if (!paused && sent_words - start >= budget / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored noise, empty frame, one-word frame, bad CRC,
      // a length over both limits
      send_word(8'h00);
      send_frame(8'hFF, 8'h00, 8'd0, 0, 1'b0, 0);
      send_frame(8'h00, 8'hFF, 8'd1, 8'hFF, 1'b0, 0);
      send_frame(8'h5A, 8'hA5, 8'd2, -1, 1'b1, 0);
      send_frame(8'h01, 8'h02, 8'hFF, 0, 1'b0, 4);

      // phases: registers at their extremes and idling patterns
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               set_config(8'h00, 8'd64);
            end
            1: begin
               send_idle_pct = 74;
               rsp_stall_pct = 0;
               set_config(8'hFF, 8'd0);
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 74;
               set_config(fpp_pkg::BYTE_W'($urandom), 8'd1);
            end
            default: begin
               send_idle_pct = 28;
               rsp_stall_pct = 28;
               set_config(fpp_pkg::BYTE_W'($urandom),
                          fpp_pkg::BYTE_W'($urandom_range(2, 15)));
            end
         endcase
         random_traffic(PHASE_BUDGET, ph == 0);
      end

      drain();
      if (book.mismatches == 0 && book.due_payload_words.size() == 0) begin
         $display("[framed_packet_parser_crc16] OK");
      end else begin
         $display("[framed_packet_parser_crc16] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/fpp_pkg.sv
rtl/core/fpp_ctrl.sv
rtl/core/fpp_dpath.sv
rtl/core/framed_packet_parser_crc16.sv
test/framed_packet_parser_crc16_tb.sv
